[src/periodic_timer_slot_table_core_defines.svh]
// assertion helpers for the timer slot table
`ifndef PERIODIC_TIMER_SLOT_TABLE_CORE_DEFINES_SVH
`define PERIODIC_TIMER_SLOT_TABLE_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PTST_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptst check failed");

// next-cycle implication, checked out of reset
`define PTST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ptst check failed");

`endif

[src/ptst_pkg.sv]
`default_nettype none
package ptst_pkg;

  // table size, 1 to 64
  localparam int SLOTS      = 16;
  localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // fixed field widths
  localparam int PERIOD_W     = 32;
  localparam int HANDLER_W    = 8;
  localparam int SLOT_FIELD_W = 4;

  // command queue depth, power of two
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = QPTR_W + 1;

  // opcodes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // result kinds
  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_FIRE  = 1'b1;

  typedef struct packed {
    logic                 is_tick;
    logic [PERIOD_W-1:0]  limit;
    logic [HANDLER_W-1:0] handler;
  } cmd_t;

  // slot number as reported, modulo 16
  function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[SLOT_FIELD_W-1:0];
  endfunction

endpackage
`default_nettype wire

[src/ptst_front.sv]
`default_nettype none
module ptst_front import ptst_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 opcode,
  input  wire logic [PERIOD_W-1:0]  period,
  input  wire logic [HANDLER_W-1:0] handler_id,
  output logic                      push_valid,
  input  wire logic                 push_ready,
  output cmd_t                      push_cmd
);

  logic stg_valid;
  cmd_t stg_cmd;

  assign in_ready   = !stg_valid || push_ready;
  assign push_valid = stg_valid;
  assign push_cmd   = stg_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
  end

  // classify and turn period into the inclusive limit
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_cmd.is_tick <= (opcode == OP_TICK);
      stg_cmd.limit   <= period - PERIOD_W'(1);
      stg_cmd.handler <= handler_id;
    end
  end

endmodule
`default_nettype wire

[src/ptst_cmd_fifo.sv]
`default_nettype none
module ptst_cmd_fifo import ptst_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire cmd_t push_cmd,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_cmd
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (cnt != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

[src/ptst_back.sv]
`default_nettype none
`include "periodic_timer_slot_table_core_defines.svh"
module ptst_back import ptst_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    pop_valid,
  output logic                         pop_ready,
  input  wire cmd_t                    pop_cmd,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         kind,
  output logic                         ok,
  output logic [SLOT_FIELD_W-1:0]      slot,
  output logic [HANDLER_W-1:0]         fired_handler,
  output logic                         last
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(SLOTS - 1);

  // slot table
  logic [SLOTS-1:0]     busy;
  logic [PERIOD_W-1:0]  slot_count   [SLOTS];
  logic [PERIOD_W-1:0]  slot_limit   [SLOTS];
  logic [HANDLER_W-1:0] slot_handler [SLOTS];

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [SLOT_IDX_W-1:0] idx;
  logic [SLOT_IDX_W-1:0] idx_next;

  // one fire held back until we know whether it is the last
  logic                  pend_valid;
  logic                  pend_valid_next;
  logic [SLOT_IDX_W-1:0] pend_idx;
  logic [HANDLER_W-1:0]  pend_handler;

  logic                  out_free;
  logic                  pop;
  logic                  free_found;
  logic [SLOT_IDX_W-1:0] free_idx;
  logic [PERIOD_W-1:0]   cur_inc;
  logic                  cur_fire;
  logic                  step;

  logic                    out_load;
  logic                    kind_d;
  logic                    ok_d;
  logic [SLOT_FIELD_W-1:0] slot_d;
  logic [HANDLER_W-1:0]    hnd_d;
  logic                    last_d;
  logic                    tbl_add;
  logic                    pend_set;

  assign out_free  = !out_valid || out_ready;
  assign pop_ready = (state == ST_IDLE) && out_free;
  assign pop       = pop_valid && pop_ready;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_IDX_W'(i);
      end
    end
  end

  assign cur_inc  = slot_count[idx] + PERIOD_W'(1);
  assign cur_fire = busy[idx] && (cur_inc > slot_limit[idx]);
  // a second fire can only move on if the held one can go out
  assign step     = (state == ST_SCAN) && (!(cur_fire && pend_valid) || out_free);

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    pend_valid_next = pend_valid;
    out_load        = 1'b0;
    kind_d          = KIND_REPLY;
    ok_d            = 1'b0;
    slot_d          = '0;
    hnd_d           = '0;
    last_d          = 1'b0;
    tbl_add         = 1'b0;
    pend_set        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (pop) begin
          if (pop_cmd.is_tick) begin
            state_next = ST_SCAN;
            idx_next   = '0;
          end else begin
            out_load = 1'b1;
            kind_d   = KIND_REPLY;
            ok_d     = free_found;
            slot_d   = free_found ? slot_field(free_idx) : '0;
            last_d   = 1'b1;
            tbl_add  = free_found;
          end
        end
      end
      ST_SCAN: begin
        if (step) begin
          if (cur_fire) begin
            pend_set        = 1'b1;
            pend_valid_next = 1'b1;
            if (pend_valid) begin
              out_load = 1'b1;
              kind_d   = KIND_FIRE;
              ok_d     = 1'b1;
              slot_d   = slot_field(pend_idx);
              hnd_d    = pend_handler;
              last_d   = 1'b0;
            end
          end
          if (idx == LAST_IDX) begin
            state_next = ST_FLUSH;
          end else begin
            idx_next = idx + SLOT_IDX_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          out_load        = 1'b1;
          kind_d          = KIND_FIRE;
          ok_d            = 1'b1;
          slot_d          = slot_field(pend_idx);
          hnd_d           = pend_handler;
          last_d          = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      busy       <= '0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      pend_valid <= pend_valid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (tbl_add) begin
        busy[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind          <= kind_d;
      ok            <= ok_d;
      slot          <= slot_d;
      fired_handler <= hnd_d;
      last          <= last_d;
    end
    if (pend_set) begin
      pend_idx     <= idx;
      pend_handler <= slot_handler[idx];
    end
    if (tbl_add) begin
      slot_count[free_idx]   <= '0;
      slot_limit[free_idx]   <= pop_cmd.limit;
      slot_handler[free_idx] <= pop_cmd.handler;
    end
    if (step && busy[idx]) begin
      slot_count[idx] <= cur_fire ? '0 : cur_inc;
    end
  end

  `PTST_IMPLIES(a_pend_in_scan, pend_valid, (state == ST_SCAN) || (state == ST_FLUSH))
  `PTST_NEXT(a_busy_sticky, 1'b1, (busy & $past(busy)) == $past(busy))
  `PTST_NEXT(a_add_claims, tbl_add, $countones(busy) == $countones($past(busy)) + 1)
  `PTST_IMPLIES(a_count_bound, (state == ST_SCAN) && busy[idx], slot_count[idx] <= slot_limit[idx])

endmodule
`default_nettype wire

[src/periodic_timer_slot_table_core.sv]
`default_nettype none
// channel  | handshake           | beat payload
// ---------+---------------------+--------------------------------------------
// in       | in_valid / in_ready | opcode, period, handler_id
// out      | out_valid/out_ready | kind, ok, slot, fired_handler, last
//
// an add goes from input beat to reply through the input stage, the queue and
// the registered output of the back end, with a priority pick of the lowest free slot
// a tick walks the slot table one slot per cycle in the back end, unless a fire
// has to wait while out_ready holds the output off
// the input stage and a 2-deep command queue keep taking beats during a scan until both are full
// sync active-high reset empties the table; no clearing pass is needed
`include "periodic_timer_slot_table_core_defines.svh"
module periodic_timer_slot_table_core import ptst_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    opcode,
  input  wire logic [PERIOD_W-1:0]     period,
  input  wire logic [HANDLER_W-1:0]    handler_id,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         kind,
  output logic                         ok,
  output logic [SLOT_FIELD_W-1:0]      slot,
  output logic [HANDLER_W-1:0]         fired_handler,
  output logic                         last
);

  // front to queue
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;

  // queue to back end
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  // accept beats, classify add vs tick, precompute limit = period - 1
  ptst_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .period     (period),
    .handler_id (handler_id),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // short command queue so the front keeps going while a tick scans
  ptst_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // slot table, add/scan sequencer and registered output beat
  ptst_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_cmd       (pop_cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .ok            (ok),
    .slot          (slot),
    .fired_handler (fired_handler),
    .last          (last)
  );

  // add replies never carry a handler id
  `PTST_IMPLIES(a_reply_clean, out_valid && (kind == KIND_REPLY), (fired_handler == '0) && last)
  // fires are always successful
  `PTST_IMPLIES(a_fire_ok, out_valid && (kind == KIND_FIRE), ok)
  // a failed add reports slot zero
  `PTST_IMPLIES(a_fail_slot, out_valid && (kind == KIND_REPLY) && !ok, slot == '0)

endmodule
`default_nettype wire
